// ===== rtl/core/plpi_pkg.sv =====
// Package for the piecewise linear path interpolator: widths, codes, queue entry types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plpi_pkg;
   localparam int CoordW     = 32;
   localparam int Dim        = 3;
   localparam int MaxCorners = 16;
   localparam int CornerW    = 4;
   localparam int StepsW     = 10;
   localparam int CountW     = 5;
   localparam int IdxW       = 14;
   localparam int DiffW      = CoordW + 1;
   localparam int ProdW      = DiffW + StepsW + 1;
   localparam int RowW       = CoordW * Dim;

   localparam logic [0:0] CMD_WRITE = 1'b0;
   localparam logic [0:0] CMD_QUERY = 1'b1;
   localparam logic [0:0] REG_STEPS = 1'b0;
   localparam logic [0:0] REG_COUNT = 1'b1;

   typedef struct packed {
      logic [StepsW-1:0] steps;
      logic [IdxW-1:0]   total;
      logic              err;
      logic              idx_zero;
      logic              dir_chg;
      logic [StepsW-1:0] off;
      logic [CornerW-1:0] seg;
      logic [CornerW-1:0] dseg;
   } job_type;
endpackage
`default_nettype wire

// ===== rtl/core/plpi_ram.sv =====
// Generic single-write, dual registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module plpi_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_a,
   input  wire logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic      [Width-1:0]         rd_data_a,
   output logic      [Width-1:0]         rd_data_b
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/plpi_front.sv =====
// Front end: classifies items, decodes a query into segment and offset.
// Depends on plpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plpi_front import plpi_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [0:0]         cmd,
   input  wire logic [IdxW-1:0]    path_index,
   input  wire logic [StepsW-1:0]  steps_cfg,
   input  wire logic [CountW-1:0]  count_cfg,
   input  wire logic               q_ready,
   output logic                    q_valid,
   output job_type                 q_job
);
   // Stage 0 pipeline: compute total, then iterate division over one stage
   // using a reciprocal-free compare chain is too deep; instead divide by
   // subtracting multiples via a 4-bit quotient (segments < 16).
   logic [StepsW-1:0] steps;
   logic [CountW-1:0] cc;
   logic [IdxW-1:0]   total, idm1;
   logic              err;
   logic [CornerW-1:0] seg, dseg;
   logic [IdxW-1:0]   rem, drem;
   logic              v_ff;
   job_type           job_ff, job_in;

   // Quotient below 16: four restoring steps on narrow values.
   function automatic logic [CornerW+IdxW-1:0] div16(input logic [IdxW-1:0] n,
                                                     input logic [StepsW-1:0] s);
      logic [IdxW-1:0] r;
      logic [CornerW-1:0] q;
      logic [IdxW+CornerW-1:0] t;
      r = n;
      q = '0;
      for (int b = CornerW-1; b >= 0; b--) begin
         t = {{CornerW{1'b0}}, {(IdxW-StepsW){1'b0}}, s} << b;
         if ({{CornerW{1'b0}}, r} >= t) begin
            r = r - t[IdxW-1:0];
            q[b] = 1'b1;
         end
      end
      return {q, r};
   endfunction

   always_comb begin
      steps = (steps_cfg == '0) ? StepsW'(1) : steps_cfg;
      cc = (count_cfg == '0) ? CountW'(1) :
           (count_cfg > CountW'(MaxCorners)) ? CountW'(MaxCorners) : count_cfg;
      total = IdxW'(1) + IdxW'(cc - CountW'(1)) * IdxW'(steps);
      err = path_index >= total;
      idm1 = path_index - IdxW'(1);
      {seg, rem}   = div16(path_index, steps);
      {dseg, drem} = div16(idm1, steps);
      job_in.steps = steps;
      job_in.total = total;
      job_in.err = err;
      job_in.idx_zero = path_index == '0;
      job_in.dir_chg = (path_index == '0) || (drem == '0);
      job_in.off = rem[StepsW-1:0];
      job_in.seg = seg;
      job_in.dseg = (path_index == '0) ? '0 : dseg;
   end

   assign in_ready = !v_ff || q_ready;
   assign q_valid = v_ff;
   assign q_job = job_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid && cmd == CMD_QUERY;
      if (in_ready && in_valid && cmd == CMD_QUERY) job_ff <= job_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/plpi_back.sv =====
// Back end: reads corners, multiplies, divides by steps over a pipelined
// restoring divider, and holds the result. Depends on plpi_pkg, plpi_ram.
`timescale 1ns / 1ps
`default_nettype none
module plpi_back import plpi_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [CornerW-1:0]  wr_addr,
   input  wire logic [RowW-1:0]     wr_data,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire job_type             q_job,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [CoordW-1:0]        pt [Dim],
   output logic [CoordW-1:0]        dl [Dim],
   output logic                     dir_chg,
   output logic                     err,
   output logic [IdxW-1:0]          total
);
   // Stages: R (RAM read seg/seg+1 then dseg/dseg+1 in alternate halves is
   // avoided: two RAM instances), M (multiply), D0..D(ProdW-1) (divide bits).
   localparam int NStg = ProdW;
   logic adv;
   logic [RowW-1:0] a0, a1, b0, b1;
   logic r_v_ff;
   job_type r_job_ff;

   plpi_ram #(.Width(RowW), .Depth(MaxCorners)) u_ram_p (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_en(adv),
      .rd_addr_a(q_job.seg), .rd_addr_b(q_job.seg + CornerW'(1)),
      .rd_data_a(a0), .rd_data_b(a1));
   plpi_ram #(.Width(RowW), .Depth(MaxCorners)) u_ram_d (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_en(adv),
      .rd_addr_a(q_job.dseg), .rd_addr_b(q_job.dseg + CornerW'(1)),
      .rd_data_a(b0), .rd_data_b(b1));

   // Whole pipeline stalls together when the output is held.
   assign adv = !out_valid || out_ready;
   assign q_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) r_v_ff <= 1'b0;
      else if (adv) r_v_ff <= q_valid;
      if (adv) r_job_ff <= q_job;
   end

   // Divider: one quotient bit per stage, remainders narrow (< 2*steps).
   logic v_ff [NStg+1];
   job_type j_ff [NStg+1];
   logic [ProdW-1:0] pq_ff [NStg+1][Dim], dq_ff [NStg+1][Dim];
   logic [StepsW:0]  pr_ff [NStg+1][Dim], dr_ff [NStg+1][Dim];
   logic sp_ff [NStg+1][Dim], sd_ff [NStg+1][Dim];
   logic [CoordW-1:0] bs_ff [NStg+1][Dim], cz_ff [NStg+1][Dim];

   // Multiply stage: numerators for point and delta (magnitudes + signs),
   // loaded straight into the head of the divider.
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= r_v_ff;
      if (adv) begin
         j_ff[0] <= r_job_ff;
         for (int d = 0; d < Dim; d++) begin
            logic signed [DiffW-1:0] pd, dd;
            logic signed [ProdW-1:0] pp;
            pd = DiffW'($signed(a1[d*CoordW +: CoordW])) -
                 DiffW'($signed(a0[d*CoordW +: CoordW]));
            dd = DiffW'($signed(b1[d*CoordW +: CoordW])) -
                 DiffW'($signed(b0[d*CoordW +: CoordW]));
            pp = ProdW'(pd) * $signed({1'b0, r_job_ff.off});
            sp_ff[0][d] <= pp[ProdW-1];
            pq_ff[0][d] <= pp[ProdW-1] ? ProdW'(-pp) : pp;
            sd_ff[0][d] <= dd[DiffW-1];
            dq_ff[0][d] <= dd[DiffW-1] ? ProdW'(-ProdW'(dd)) : ProdW'(dd);
            pr_ff[0][d] <= '0;
            dr_ff[0][d] <= '0;
            bs_ff[0][d] <= a0[d*CoordW +: CoordW];
            cz_ff[0][d] <= b0[d*CoordW +: CoordW];
         end
      end
   end

   for (genvar k = 0; k < NStg; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else if (adv) v_ff[k+1] <= v_ff[k];
         if (adv) begin
            j_ff[k+1] <= j_ff[k];
            for (int d = 0; d < Dim; d++) begin
               logic [StepsW+1:0] tp, td;
               tp = {pr_ff[k][d], pq_ff[k][d][ProdW-1]};
               td = {dr_ff[k][d], dq_ff[k][d][ProdW-1]};
               if (tp >= {2'b0, j_ff[k].steps}) begin
                  pr_ff[k+1][d] <= (StepsW+1)'(tp - {2'b0, j_ff[k].steps});
                  pq_ff[k+1][d] <= {pq_ff[k][d][ProdW-2:0], 1'b1};
               end else begin
                  pr_ff[k+1][d] <= tp[StepsW:0];
                  pq_ff[k+1][d] <= {pq_ff[k][d][ProdW-2:0], 1'b0};
               end
               if (td >= {2'b0, j_ff[k].steps}) begin
                  dr_ff[k+1][d] <= (StepsW+1)'(td - {2'b0, j_ff[k].steps});
                  dq_ff[k+1][d] <= {dq_ff[k][d][ProdW-2:0], 1'b1};
               end else begin
                  dr_ff[k+1][d] <= td[StepsW:0];
                  dq_ff[k+1][d] <= {dq_ff[k][d][ProdW-2:0], 1'b0};
               end
               sp_ff[k+1][d] <= sp_ff[k][d];
               sd_ff[k+1][d] <= sd_ff[k][d];
               bs_ff[k+1][d] <= bs_ff[k][d];
               cz_ff[k+1][d] <= cz_ff[k][d];
            end
         end
      end
   end

   // Output register.
   logic o_v_ff;
   logic [CoordW-1:0] pt_ff [Dim], dl_ff [Dim];
   logic dir_ff, err_ff;
   logic [IdxW-1:0] tot_ff;
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (adv) o_v_ff <= v_ff[NStg];
      if (adv) begin
         tot_ff <= j_ff[NStg].total;
         err_ff <= j_ff[NStg].err;
         dir_ff <= !j_ff[NStg].err && j_ff[NStg].dir_chg;
         for (int d = 0; d < Dim; d++) begin
            logic [CoordW-1:0] qp, qd;
            qp = sp_ff[NStg][d] ? CoordW'(-pq_ff[NStg][d]) : CoordW'(pq_ff[NStg][d]);
            qd = sd_ff[NStg][d] ? CoordW'(-dq_ff[NStg][d]) : CoordW'(dq_ff[NStg][d]);
            pt_ff[d] <= j_ff[NStg].err ? '0 : bs_ff[NStg][d] + qp;
            dl_ff[d] <= j_ff[NStg].err ? '0 :
                        j_ff[NStg].idx_zero ? cz_ff[NStg][d] : qd;
         end
      end
   end

   assign out_valid = o_v_ff;
   assign pt = pt_ff;
   assign dl = dl_ff;
   assign dir_chg = dir_ff;
   assign err = err_ff;
   assign total = tot_ff;
endmodule
`default_nettype wire

// ===== rtl/core/piecewise_linear_path_interpolator_core.sv =====
// Piecewise linear path interpolator, top level.
// Throughput: one transfer per cycle while not stalled; corner writes and queries both.
// Path of a query: front register, RAM read, multiply, 44 one-bit divider stages,
// output register; a held result stalls the whole pipeline. Reset: synchronous,
// clears control state; registers return to steps=1, count=1. Corner table is
// undefined until written. Depends on plpi_pkg, plpi_front, plpi_back.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_path_interpolator_core import plpi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [0:0]           req_cmd,
   input  wire logic [CornerW-1:0]   req_corner_index,
   input  wire logic signed [CoordW-1:0] req_coord_x,
   input  wire logic signed [CoordW-1:0] req_coord_y,
   input  wire logic signed [CoordW-1:0] req_coord_z,
   input  wire logic [IdxW-1:0]      req_path_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [CoordW-1:0]  rsp_point_x,
   output logic signed [CoordW-1:0]  rsp_point_y,
   output logic signed [CoordW-1:0]  rsp_point_z,
   output logic signed [CoordW-1:0]  rsp_delta_x,
   output logic signed [CoordW-1:0]  rsp_delta_y,
   output logic signed [CoordW-1:0]  rsp_delta_z,
   output logic                      rsp_direction_changed,
   output logic                      rsp_index_error,
   output logic [IdxW-1:0]           rsp_total_steps,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [0:0]           csr_index,
   input  wire logic [31:0]          csr_data
);
   logic [StepsW-1:0] steps_ff;
   logic [CountW-1:0] count_ff;
   logic q_valid, q_ready, wr_en;
   job_type q_job;
   logic [CoordW-1:0] pt [Dim], dl [Dim];

   // Register writes always complete; index is only the list position.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= StepsW'(1);
         count_ff <= CountW'(1);
      end else if (csr_valid) begin
         case (csr_index)
            REG_STEPS: steps_ff <= csr_data[StepsW-1:0];
            REG_COUNT: count_ff <= csr_data[CountW-1:0];
            default:   ;
         endcase
      end
   end

   // Write a corner straight into both table copies on transfer.
   assign wr_en = req_valid && req_ready && req_cmd == CMD_WRITE;

   plpi_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready),
      .cmd(req_cmd), .path_index(req_path_index),
      .steps_cfg(steps_ff), .count_cfg(count_ff),
      .q_ready, .q_valid, .q_job);

   plpi_back u_back (
      .clock, .reset, .wr_en, .wr_addr(req_corner_index),
      .wr_data({req_coord_z, req_coord_y, req_coord_x}),
      .q_valid, .q_ready, .q_job,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .pt, .dl,
      .dir_chg(rsp_direction_changed), .err(rsp_index_error),
      .total(rsp_total_steps));

   assign rsp_point_x = pt[0];
   assign rsp_point_y = pt[1];
   assign rsp_point_z = pt[2];
   assign rsp_delta_x = dl[0];
   assign rsp_delta_y = dl[1];
   assign rsp_delta_z = dl[2];

   // An error result carries zero point and no direction flag.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> !rsp_direction_changed && rsp_point_x == '0)
      else $error("error result carries data");
   // A held result stays put while the consumer stalls.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_steps))
      else $error("stalled result changed");
   // Total step count is never zero.
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_steps != '0)
      else $error("zero total");
endmodule
`default_nettype wire
